FILE: rtl/cvg_pkg.sv
// Shared types and constants of the circle vertex generator.
// Holds the fixed-point widths, the register indexes and the CORDIC angle table.
// No dependencies.
package cvg_pkg;

    localparam int MAX_SEGMENTS = 4096;
    localparam int IDX_W        = 12;
    localparam int CNT_W        = 13;
    localparam int COORD_W      = 16;
    localparam int RAD_W        = 15;
    localparam int PHASE_W      = 32;
    localparam int DIV_STAGES   = PHASE_W;
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W         = 34;
    localparam int Z_W          = 32;
    localparam int UNIT_W       = 32;
    localparam int PROD_W       = 48;
    localparam int ACC_W        = 49;

    localparam logic [XY_W-1:0] CORDIC_GAIN_Q30 = XY_W'(652032874);
    localparam logic [ACC_W-1:0] HALF_Q30 = ACC_W'(536870912);

    localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] REG_RADIUS        = 3'd2;
    localparam logic [2:0] REG_SEGMENT_COUNT = 3'd3;

    typedef struct packed {
        logic valid;
        logic err;
    } cvg_tag_t;

    function automatic logic [Z_W-1:0] atan_turn(input int i);
        logic [Z_W-1:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/cvg_divider.sv
// Pipelined restoring divider that turns a vertex index into a phase.
// One quotient bit per stage; depends on cvg_pkg.
module cvg_divider
    import cvg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  cvg_tag_t             tag_in,
    input  logic [IDX_W-1:0]     index_in,
    input  logic [CNT_W-1:0]     n_eff,
    output cvg_tag_t             tag_out,
    output logic [PHASE_W-1:0]   phase_out
);

    logic [CNT_W-1:0]   rem_reg [DIV_STAGES];
    logic [PHASE_W-1:0] quo_reg [DIV_STAGES];
    cvg_tag_t           tag_reg [DIV_STAGES];
    logic [PHASE_W-1:0] low_word;

    // Low dividend word is n/2, which implements round to nearest.
    assign low_word = {{(PHASE_W-CNT_W+1){1'b0}}, n_eff[CNT_W-1:1]};

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [CNT_W-1:0]   rem_in;
            logic [PHASE_W-1:0] quo_in;
            cvg_tag_t           tag_in_k;
            logic [CNT_W:0]     trial;
            logic               ge;

            if (k == 0)
            begin : g_first
                assign rem_in   = {1'b0, index_in};
                assign quo_in   = '0;
                assign tag_in_k = tag_in;
            end
            else
            begin : g_rest
                assign rem_in   = rem_reg[k-1];
                assign quo_in   = quo_reg[k-1];
                assign tag_in_k = tag_reg[k-1];
            end

            assign trial = {rem_in, low_word[PHASE_W-1-k]};
            assign ge    = trial >= {1'b0, n_eff};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[k] <= '0;
                end
                else if (adv)
                begin
                    tag_reg[k] <= tag_in_k;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= ge ? CNT_W'(trial - {1'b0, n_eff}) : CNT_W'(trial);
                    quo_reg[k] <= {quo_in[PHASE_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign tag_out   = tag_reg[DIV_STAGES-1];
    assign phase_out = quo_reg[DIV_STAGES-1];

endmodule

FILE: rtl/cvg_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
// Produces cosine and sine in Q30 for the first quadrant; depends on cvg_pkg.
module cvg_cordic
    import cvg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  cvg_tag_t             tag_in,
    input  logic [PHASE_W-1:0]   phase_in,
    output cvg_tag_t             tag_out,
    output logic [1:0]           quad_out,
    output logic signed [XY_W-1:0] cos_out,
    output logic signed [XY_W-1:0] sin_out
);

    logic signed [XY_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STEPS];
    logic [1:0]             q_reg [CORDIC_STEPS];
    cvg_tag_t               tag_reg [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            logic signed [XY_W-1:0] x_in;
            logic signed [XY_W-1:0] y_in;
            logic signed [Z_W-1:0]  z_in;
            logic [1:0]             q_in;
            cvg_tag_t               t_in;
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;
            logic signed [Z_W-1:0]  a;

            if (i == 0)
            begin : g_first
                assign x_in = CORDIC_GAIN_Q30;
                assign y_in = '0;
                assign z_in = {2'b00, phase_in[PHASE_W-3:0]};
                assign q_in = phase_in[PHASE_W-1:PHASE_W-2];
                assign t_in = tag_in;
            end
            else
            begin : g_rest
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign q_in = q_reg[i-1];
                assign t_in = tag_reg[i-1];
            end

            assign dx = y_in >>> i;
            assign dy = x_in >>> i;
            assign a  = atan_turn(i);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[i] <= '0;
                end
                else if (adv)
                begin
                    tag_reg[i] <= t_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    q_reg[i] <= q_in;
                    if (!z_in[Z_W-1])
                    begin
                        x_reg[i] <= x_in - dx;
                        y_reg[i] <= y_in + dy;
                        z_reg[i] <= z_in - a;
                    end
                    else
                    begin
                        x_reg[i] <= x_in + dx;
                        y_reg[i] <= y_in - dy;
                        z_reg[i] <= z_in + a;
                    end
                end
            end
        end
    endgenerate

    assign tag_out  = tag_reg[CORDIC_STEPS-1];
    assign quad_out = q_reg[CORDIC_STEPS-1];
    assign cos_out  = x_reg[CORDIC_STEPS-1];
    assign sin_out  = y_reg[CORDIC_STEPS-1];

endmodule

FILE: rtl/cvg_place.sv
// Quadrant unfold, radius scaling, centre offset, rounding and saturation.
// Three register stages, the last one is the output register; depends on cvg_pkg.
module cvg_place
    import cvg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  cvg_tag_t               tag_in,
    input  logic [1:0]             quad_in,
    input  logic signed [XY_W-1:0] cos_in,
    input  logic signed [XY_W-1:0] sin_in,
    input  logic [RAD_W-1:0]       radius,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    output cvg_tag_t               tag_out,
    output logic [COORD_W-1:0]     vertex_x,
    output logic [COORD_W-1:0]     vertex_y
);

    cvg_tag_t tag1_reg, tag2_reg, tag3_reg;
    logic signed [UNIT_W-1:0]  ux_reg, uy_reg;
    logic signed [PROD_W-1:0]  px_reg, py_reg;
    logic [COORD_W-1:0]        vx_reg, vy_reg;
    logic signed [UNIT_W-1:0]  ux_next, uy_next;
    logic signed [XY_W-1:0]    cn, sn;

    assign cn = -cos_in;
    assign sn = -sin_in;

    always_comb
    begin
        case (quad_in)
            2'd1:
            begin
                ux_next = sn[UNIT_W-1:0];
                uy_next = cos_in[UNIT_W-1:0];
            end
            2'd2:
            begin
                ux_next = cn[UNIT_W-1:0];
                uy_next = sn[UNIT_W-1:0];
            end
            2'd3:
            begin
                ux_next = sin_in[UNIT_W-1:0];
                uy_next = cn[UNIT_W-1:0];
            end
            default:
            begin
                ux_next = cos_in[UNIT_W-1:0];
                uy_next = sin_in[UNIT_W-1:0];
            end
        endcase
    end

    function automatic logic [COORD_W-1:0] offset_round(
        input logic signed [PROD_W-1:0]  p,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-31:0] r;
        logic [COORD_W-1:0] v;
        acc = ACC_W'(p) + (ACC_W'(c) <<< 30) + $signed(HALF_Q30);
        r   = acc[ACC_W-1:30];
        if (r > 32767)
            v = 16'h7FFF;
        else if (r < -32768)
            v = 16'h8000;
        else
            v = r[COORD_W-1:0];
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            px_reg <= PROD_W'($signed({1'b0, radius})) * PROD_W'(ux_reg);
            py_reg <= PROD_W'($signed({1'b0, radius})) * PROD_W'(uy_reg);
            if (tag2_reg.err)
            begin
                vx_reg <= '0;
                vy_reg <= '0;
            end
            else
            begin
                vx_reg <= offset_round(px_reg, origin_x);
                vy_reg <= offset_round(py_reg, origin_y);
            end
        end
    end

    assign tag_out  = tag3_reg;
    assign vertex_x = vx_reg;
    assign vertex_y = vy_reg;

endmodule

FILE: rtl/circle_vertex_generator_unit.sv
// Top level of the circle vertex generator: configuration registers and stream ports.
// Instantiates cvg_divider, cvg_cordic and cvg_place; depends on cvg_pkg.
//
// One vertex index is taken per clock cycle and one vertex leaves per cycle while the
// output is not stalled. The pipeline has 32 divider stages that form the phase one
// quotient bit at a time, 24 CORDIC stages, and three stages for the quadrant unfold,
// the radius multiply and the offset with rounding and saturation. When the output is
// stalled the whole pipeline holds. Indexes at or beyond the segment count (capped at
// 4096) come out as zero coordinates with the error flag set. Write the registers only
// while no transaction is in flight.
module circle_vertex_generator_unit
    import cvg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] vertex_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] vertex_x, [31:16] vertex_y
    output logic        m_tuser,    // [0] index_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [RAD_W-1:0]   radius_reg;
    logic [CNT_W-1:0]   seg_reg;
    logic [CNT_W-1:0]   n_eff;
    logic [IDX_W-1:0]   index_in;
    logic               adv;
    cvg_tag_t           tag_in, tag_div, tag_cor, tag_out;
    logic [PHASE_W-1:0] phase;
    logic [1:0]         quad;
    logic signed [XY_W-1:0] cos_v, sin_v;
    logic [COORD_W-1:0] vx, vy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            radius_reg   <= RAD_W'(1280);
            seg_reg      <= CNT_W'(100);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORIGIN_X:      origin_x_reg <= cfg_data;
                REG_ORIGIN_Y:      origin_y_reg <= cfg_data;
                REG_RADIUS:        radius_reg   <= cfg_data[RAD_W-1:0];
                REG_SEGMENT_COUNT: seg_reg      <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign n_eff    = (seg_reg > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : seg_reg;
    assign index_in = s_tdata[IDX_W-1:0];
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    assign tag_in.valid = s_tvalid;
    assign tag_in.err   = {1'b0, index_in} >= n_eff;

    cvg_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .tag_in    (tag_in),
        .index_in  (index_in),
        .n_eff     (n_eff),
        .tag_out   (tag_div),
        .phase_out (phase)
    );

    cvg_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .tag_in   (tag_div),
        .phase_in (phase),
        .tag_out  (tag_cor),
        .quad_out (quad),
        .cos_out  (cos_v),
        .sin_out  (sin_v)
    );

    cvg_place u_place (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .tag_in   (tag_cor),
        .quad_in  (quad),
        .cos_in   (cos_v),
        .sin_in   (sin_v),
        .radius   (radius_reg),
        .origin_x ($signed(origin_x_reg)),
        .origin_y ($signed(origin_y_reg)),
        .tag_out  (tag_out),
        .vertex_x (vx),
        .vertex_y (vy)
    );

    assign m_tvalid = tag_out.valid;
    assign m_tdata  = {vy, vx};
    assign m_tuser  = tag_out.err;

    // An errored vertex always carries zero coordinates.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error vertex with nonzero coordinates");

    // The effective count never exceeds the maximum.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_eff <= CNT_W'(MAX_SEGMENTS))
        else $error("effective segment count above maximum");

    // Input is refused only while a finished vertex waits downstream.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // Nothing leaves in the cycle after reset is released.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule
